@@ src/gnpm_pkg.sv @@
// ----------------------------------------------------------------------------
// gnpm_pkg
// Shared types, codes and widths for the grid nearest-point lookup core.
// ----------------------------------------------------------------------------
`default_nettype none

package gnpm_pkg;

    // defaults for the top-level parameters
    localparam int MAX_POINTS_DEF = 64;
    localparam int VALUE_BITS_DEF = 32;

    // field widths
    localparam int OP_W     = 2;
    localparam int COORD_W  = 10;
    localparam int SVAL_W   = 32;
    localparam int SEED_W   = 16;
    localparam int GRID_W   = 9;
    localparam int STATUS_W = 2;
    localparam int TIES_W   = 7;
    localparam int DIST_W   = 11;

    // stream word widths (packed fields padded to whole bytes)
    localparam int S_TDATA_W = 72;
    localparam int S_TUSER_W = OP_W;
    localparam int M_TDATA_W = 48;

    // input word layout
    localparam int S_ROW_LSB  = 0;
    localparam int S_COL_LSB  = 10;
    localparam int S_SVAL_LSB = 20;
    localparam int S_SEED_LSB = 52;

    // output word layout
    localparam int M_STATUS_LSB = 0;
    localparam int M_FOUND_BIT  = 2;
    localparam int M_VALUE_LSB  = 3;
    localparam int M_TIES_LSB   = 35;

    // operation codes
    localparam logic [OP_W-1:0] OP_CLEAR = 2'd0;
    localparam logic [OP_W-1:0] OP_ADD   = 2'd1;
    localparam logic [OP_W-1:0] OP_QUERY = 2'd2;

    // status codes
    localparam logic [STATUS_W-1:0] ST_OK      = 2'd0;
    localparam logic [STATUS_W-1:0] ST_FULL    = 2'd1;
    localparam logic [STATUS_W-1:0] ST_OUTSIDE = 2'd2;

    // register indexes
    localparam logic REG_GRID_ROWS = 1'b0;
    localparam logic REG_GRID_COLS = 1'b1;

    localparam logic [GRID_W-1:0] GRID_RESET = 9'd256;
    localparam logic [SEED_W-1:0] LFSR_TAPS  = 16'hB400;

    // controller -> datapath
    typedef struct packed {
        logic load;     // latch the accepted word
        logic init;     // set up the search state
        logic rd_en;    // read next stored point
        logic commit;   // apply the item and load the result register
    } gnpm_cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic scan_go;  // inside query with at least one stored point
        logic last_rd;  // read address is at the last stored point
        logic busy;     // compare pipeline still holds points
        logic out_free; // result register can take a new word
    } gnpm_stat_t;

endpackage

`default_nettype wire

@@ src/gnpm_ctrl.sv @@
// ----------------------------------------------------------------------------
// gnpm_ctrl
// Item sequencer: accept, decode, scan the point table, drain, deliver.
// ----------------------------------------------------------------------------
`default_nettype none

module gnpm_ctrl (
    input  wire                 clk,
    input  wire                 rst_n,
    input  wire                 s_tvalid,
    output logic                s_tready,
    input  wire gnpm_pkg::gnpm_stat_t stat,
    output gnpm_pkg::gnpm_cmd_t  cmd
);

    typedef enum logic [2:0] {
        IDLE,
        DECODE,
        SCAN,
        DRAIN,
        FINISH
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            IDLE:
            begin
                if (s_tvalid)
                begin
                    state_next = DECODE;
                end
            end
            DECODE:
            begin
                state_next = stat.scan_go ? SCAN : FINISH;
            end
            SCAN:
            begin
                if (stat.last_rd)
                begin
                    state_next = DRAIN;
                end
            end
            DRAIN:
            begin
                if (!stat.busy)
                begin
                    state_next = FINISH;
                end
            end
            FINISH:
            begin
                if (stat.out_free)
                begin
                    state_next = IDLE;
                end
            end
            default:
            begin
                state_next = IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign s_tready   = (state_reg == IDLE);
    assign cmd.load   = (state_reg == IDLE) && s_tvalid;
    assign cmd.init   = (state_reg == DECODE);
    assign cmd.rd_en  = (state_reg == SCAN);
    assign cmd.commit = (state_reg == FINISH) && stat.out_free;

endmodule

`default_nettype wire

@@ src/gnpm_datapath.sv @@
// ----------------------------------------------------------------------------
// gnpm_datapath
// Point table, grid registers, distance/compare pipeline and result register.
// ----------------------------------------------------------------------------
`default_nettype none

module gnpm_datapath #(
    parameter int MAX_POINTS = gnpm_pkg::MAX_POINTS_DEF,
    parameter int VALUE_BITS = gnpm_pkg::VALUE_BITS_DEF
) (
    input  wire                                   clk,
    input  wire                                   rst_n,
    input  wire gnpm_pkg::gnpm_cmd_t              cmd,
    output gnpm_pkg::gnpm_stat_t                  stat,
    input  wire                                   cfg_we,
    input  wire                                   cfg_index,
    input  wire [gnpm_pkg::GRID_W-1:0]            cfg_data,
    input  wire [gnpm_pkg::OP_W-1:0]              in_op,
    input  wire [gnpm_pkg::COORD_W-1:0]           in_row,
    input  wire [gnpm_pkg::COORD_W-1:0]           in_col,
    input  wire [gnpm_pkg::SVAL_W-1:0]            in_sval,
    input  wire [gnpm_pkg::SEED_W-1:0]            in_seed,
    input  wire                                   m_tready,
    output logic                                  m_tvalid,
    output logic [gnpm_pkg::STATUS_W-1:0]         out_status,
    output logic                                  out_found,
    output logic [gnpm_pkg::SVAL_W-1:0]           out_value,
    output logic [gnpm_pkg::TIES_W-1:0]           out_ties
);

    localparam int AW = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
    localparam int CW = $clog2(MAX_POINTS + 1);
    localparam int CRD = gnpm_pkg::COORD_W;
    localparam int MW = 2 * CRD + VALUE_BITS;
    localparam int PW = gnpm_pkg::SEED_W + CW;
    localparam int DW = gnpm_pkg::DIST_W;

    // item
    logic [gnpm_pkg::OP_W-1:0]     op_reg;
    logic [CRD-1:0]                row_reg;
    logic [CRD-1:0]                col_reg;
    logic [gnpm_pkg::SVAL_W-1:0]   sval_reg;
    logic [gnpm_pkg::SEED_W-1:0]   seed_reg;

    // configuration and table fill
    logic [gnpm_pkg::GRID_W-1:0]   rows_reg;
    logic [gnpm_pkg::GRID_W-1:0]   cols_reg;
    logic [CW-1:0]                 count_reg;

    // point table: {value, col, row}
    logic [MW-1:0]                 mem [MAX_POINTS];

    // read stage
    logic [AW-1:0]                 addr_reg;
    logic [MW-1:0]                 rdata_reg;
    logic                          rd_v_reg;

    // distance stage
    logic [DW-1:0]                 dist_reg;
    logic [VALUE_BITS-1:0]         dval_reg;
    logic                          dist_v_reg;

    // search state
    logic [DW-1:0]                 best_reg;
    logic [CW-1:0]                 n_reg;
    logic [gnpm_pkg::SEED_W-1:0]   lfsr_reg;
    logic [VALUE_BITS-1:0]         choice_reg;

    logic                          in_grid;
    logic                          full;
    logic                          do_write;

    logic [CRD-1:0]                p_row;
    logic [CRD-1:0]                p_col;
    logic [CRD:0]                  dr;
    logic [CRD:0]                  dc;
    logic [CRD:0]                  dr_neg;
    logic [CRD:0]                  dc_neg;
    logic [CRD-1:0]                ar;
    logic [CRD-1:0]                ac;

    logic [gnpm_pkg::SEED_W-1:0]   lfsr_step;
    logic [CW-1:0]                 n_inc;
    logic [PW-1:0]                 prod;
    logic [PW-1:0]                 rhs;
    logic                          take_new;
    logic                          is_tie;
    logic [31:0]                   n_wide;

    // query cell inside the grid (negative rows/cols caught by the sign bit)
    assign in_grid = !row_reg[CRD-1] && !col_reg[CRD-1]
                     && (row_reg[gnpm_pkg::GRID_W-1:0] < rows_reg)
                     && (col_reg[gnpm_pkg::GRID_W-1:0] < cols_reg);
    assign full     = (count_reg >= CW'(MAX_POINTS));
    assign do_write = cmd.commit && (op_reg == gnpm_pkg::OP_ADD) && !full;

    assign stat.scan_go  = (op_reg == gnpm_pkg::OP_QUERY) && in_grid && (count_reg != '0);
    assign stat.last_rd  = (CW'(addr_reg) == (count_reg - CW'(1)));
    assign stat.busy     = rd_v_reg || dist_v_reg;
    assign stat.out_free = !m_tvalid || m_tready;

    // Manhattan distance of the fetched point
    assign p_row  = rdata_reg[CRD-1:0];
    assign p_col  = rdata_reg[2*CRD-1:CRD];
    assign dr     = {p_row[CRD-1], p_row} - {row_reg[CRD-1], row_reg};
    assign dc     = {p_col[CRD-1], p_col} - {col_reg[CRD-1], col_reg};
    assign dr_neg = -dr;
    assign dc_neg = -dc;
    assign ar     = dr[CRD] ? dr_neg[CRD-1:0] : dr[CRD-1:0];
    assign ac     = dc[CRD] ? dc_neg[CRD-1:0] : dc[CRD-1:0];

    // tie break: step the LFSR, accept when u * (n+1) > n * 2^16
    assign lfsr_step = {1'b0, lfsr_reg[gnpm_pkg::SEED_W-1:1]}
                       ^ (lfsr_reg[0] ? gnpm_pkg::LFSR_TAPS : '0);
    assign n_inc     = n_reg + CW'(1);
    assign prod      = PW'(lfsr_step) * PW'(n_inc);
    assign rhs       = PW'(n_reg) << gnpm_pkg::SEED_W;
    assign take_new  = ((n_reg == '0) || (dist_reg < best_reg)) && (dist_reg <= best_reg);
    assign is_tie    = (n_reg != '0) && (dist_reg == best_reg);
    assign n_wide    = 32'(n_reg);

    // configuration, fill count, pipeline valids, result valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rows_reg   <= gnpm_pkg::GRID_RESET;
            cols_reg   <= gnpm_pkg::GRID_RESET;
            count_reg  <= '0;
            rd_v_reg   <= 1'b0;
            dist_v_reg <= 1'b0;
            m_tvalid   <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                if (cfg_index == gnpm_pkg::REG_GRID_ROWS)
                begin
                    rows_reg <= cfg_data;
                end
                else
                begin
                    cols_reg <= cfg_data;
                end
            end
            if (cmd.commit && (op_reg == gnpm_pkg::OP_CLEAR))
            begin
                count_reg <= '0;
            end
            else if (do_write)
            begin
                count_reg <= count_reg + CW'(1);
            end
            rd_v_reg   <= cmd.rd_en;
            dist_v_reg <= rd_v_reg;
            if (cmd.commit)
            begin
                m_tvalid <= 1'b1;
            end
            else if (m_tready)
            begin
                m_tvalid <= 1'b0;
            end
        end
    end

    // point table
    always_ff @(posedge clk)
    begin
        if (do_write)
        begin
            mem[count_reg[AW-1:0]] <= {VALUE_BITS'(sval_reg), col_reg, row_reg};
        end
        if (cmd.rd_en)
        begin
            rdata_reg <= mem[addr_reg];
        end
    end

    // item, search and result payload
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            op_reg   <= in_op;
            row_reg  <= in_row;
            col_reg  <= in_col;
            sval_reg <= in_sval;
            seed_reg <= in_seed;
        end

        if (cmd.init)
        begin
            addr_reg   <= '0;
            best_reg   <= DW'(rows_reg) + DW'(cols_reg) + DW'(1);
            n_reg      <= '0;
            lfsr_reg   <= (seed_reg == '0) ? gnpm_pkg::SEED_W'(1) : seed_reg;
            choice_reg <= '0;
        end
        else if (cmd.rd_en)
        begin
            addr_reg <= addr_reg + AW'(1);
        end

        if (rd_v_reg)
        begin
            dist_reg <= DW'(ar) + DW'(ac);
            dval_reg <= rdata_reg[MW-1:2*CRD];
        end

        if (dist_v_reg)
        begin
            if (take_new)
            begin
                best_reg   <= dist_reg;
                n_reg      <= CW'(1);
                choice_reg <= dval_reg;
            end
            else if (is_tie)
            begin
                n_reg    <= n_inc;
                lfsr_reg <= lfsr_step;
                if (prod > rhs)
                begin
                    choice_reg <= dval_reg;
                end
            end
        end

        if (cmd.commit)
        begin
            out_status <= gnpm_pkg::ST_OK;
            out_found  <= 1'b0;
            out_value  <= '0;
            out_ties   <= '0;
            case (op_reg)
                gnpm_pkg::OP_ADD:
                begin
                    if (full)
                    begin
                        out_status <= gnpm_pkg::ST_FULL;
                    end
                end
                gnpm_pkg::OP_QUERY:
                begin
                    if (!in_grid)
                    begin
                        out_status <= gnpm_pkg::ST_OUTSIDE;
                    end
                    else if (n_reg != '0)
                    begin
                        out_found <= 1'b1;
                        out_value <= gnpm_pkg::SVAL_W'(choice_reg);
                        out_ties  <= (n_wide > 32'd127) ? 7'd127 : n_wide[6:0];
                    end
                end
                default:
                begin
                    out_status <= gnpm_pkg::ST_OK;
                end
            endcase
        end
    end

endmodule

`default_nettype wire

@@ src/grid_nearest_point_manhattan_core.sv @@
// ----------------------------------------------------------------------------
// grid_nearest_point_manhattan_core
// Nearest stored sample point to a grid cell, by Manhattan distance.
// ----------------------------------------------------------------------------
// Each input word clears the point table, adds a point (row, col, value) or
// queries one cell; every word gives exactly one output word. A query scans
// the stored points one per cycle through a single-port table read, a
// registered distance stage and a compare stage, keeping the nearest point;
// equal-distance points are picked uniformly by reservoir choice with a
// 16-bit Galois LFSR (taps 0xB400) seeded from the query word (zero seed
// taken as one). The search limit is grid_rows + grid_cols + 1 inclusive.
// Flow: one word is in the core at a time. Clear, add, out-of-grid
// queries and queries on an empty table go from decode to the result;
// an inside query on a non-empty table reads every stored point, one
// table read per cycle, then drains the distance and compare stages.
// The output register lets the next word be accepted while a result
// still waits on m_tready. Grid registers are written through cfg_we/
// cfg_index/cfg_data (index 0 rows, 1 columns, low 9 bits kept); the user
// must write them only while the core is idle (not enforced). The table
// needs no clearing pass: only entries below the fill count are ever read.
// ----------------------------------------------------------------------------
`default_nettype none

module grid_nearest_point_manhattan_core #(
    parameter int MAX_POINTS = gnpm_pkg::MAX_POINTS_DEF,
    parameter int VALUE_BITS = gnpm_pkg::VALUE_BITS_DEF
) (
    input  wire                              clk,
    input  wire                              rst_n,
    // configuration write port
    input  wire                              cfg_we,
    input  wire                              cfg_index,
    input  wire [gnpm_pkg::GRID_W-1:0]       cfg_data,
    // input word stream
    input  wire                              s_tvalid,
    output logic                             s_tready,
    // row[9:0], col[19:10], sample_value[51:20], seed[67:52], zero pad
    input  wire [gnpm_pkg::S_TDATA_W-1:0]    s_tdata,
    // op[1:0]
    input  wire [gnpm_pkg::S_TUSER_W-1:0]    s_tuser,
    // result word stream
    output logic                             m_tvalid,
    input  wire                              m_tready,
    // status[1:0], found[2], cell_value[34:3], tie_count[41:35], zero pad
    output logic [gnpm_pkg::M_TDATA_W-1:0]   m_tdata
);

    gnpm_pkg::gnpm_cmd_t  cmd;
    gnpm_pkg::gnpm_stat_t stat;

    logic [gnpm_pkg::STATUS_W-1:0] out_status;
    logic                          out_found;
    logic [gnpm_pkg::SVAL_W-1:0]   out_value;
    logic [gnpm_pkg::TIES_W-1:0]   out_ties;

    // sequencer
    gnpm_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    // table, search pipeline and result register
    gnpm_datapath #(
        .MAX_POINTS (MAX_POINTS),
        .VALUE_BITS (VALUE_BITS)
    ) u_dp (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .stat       (stat),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .in_op      (s_tuser),
        .in_row     (s_tdata[gnpm_pkg::S_COL_LSB-1:gnpm_pkg::S_ROW_LSB]),
        .in_col     (s_tdata[gnpm_pkg::S_SVAL_LSB-1:gnpm_pkg::S_COL_LSB]),
        .in_sval    (s_tdata[gnpm_pkg::S_SEED_LSB-1:gnpm_pkg::S_SVAL_LSB]),
        .in_seed    (s_tdata[gnpm_pkg::S_SEED_LSB+gnpm_pkg::SEED_W-1:gnpm_pkg::S_SEED_LSB]),
        .m_tready   (m_tready),
        .m_tvalid   (m_tvalid),
        .out_status (out_status),
        .out_found  (out_found),
        .out_value  (out_value),
        .out_ties   (out_ties)
    );

    // result word packing; pad bits stay zero
    assign m_tdata = {6'd0, out_ties, out_value, out_found, out_status};

endmodule

`default_nettype wire

@@ src/gnpm_checker.sv @@
// ----------------------------------------------------------------------------
// gnpm_checker
// Port-level checks on the nearest-point core, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module gnpm_checker (
    input wire                              clk,
    input wire                              rst_n,
    input wire                              s_tvalid,
    input wire                              s_tready,
    input wire                              m_tvalid,
    input wire                              m_tready,
    input wire [gnpm_pkg::M_TDATA_W-1:0]    m_tdata
);

    // a stalled result word holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result word changed or dropped while stalled");

    // one word in flight: ready drops right after an accept
    a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> !s_tready)
        else $error("input accepted while a word is still in the core");

    // no chosen point: value and tie count are zero
    a_not_found: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tdata[gnpm_pkg::M_FOUND_BIT]
        |-> m_tdata[gnpm_pkg::M_TIES_LSB+gnpm_pkg::TIES_W-1:gnpm_pkg::M_VALUE_LSB] == '0)
        else $error("value or ties set without a chosen point");

    // a chosen point comes with status ok and at least one tie
    a_found: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tdata[gnpm_pkg::M_FOUND_BIT]
        |-> m_tdata[gnpm_pkg::M_STATUS_LSB+gnpm_pkg::STATUS_W-1:gnpm_pkg::M_STATUS_LSB]
                == gnpm_pkg::ST_OK
            && m_tdata[gnpm_pkg::M_TIES_LSB+gnpm_pkg::TIES_W-1:gnpm_pkg::M_TIES_LSB] != '0)
        else $error("found result with bad status or zero ties");

endmodule

bind grid_nearest_point_manhattan_core gnpm_checker u_gnpm_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

`default_nettype wire
